### design/rws_pkg.sv
`default_nettype none

package rws_pkg;

	localparam int DEF_POP_SIZE = 64;
	localparam int FIT_W        = 16;
	localparam int FRAC_W       = 16;
	localparam int SLOT_W       = 6;

	typedef struct packed {
		logic              cmd;
		logic [SLOT_W-1:0] slot_index;
		logic [FIT_W-1:0]  fitness_value;
		logic [FRAC_W-1:0] random_fraction;
	} item_t;

	typedef struct packed {
		logic [SLOT_W-1:0] selected_slot;
		logic [FIT_W-1:0]  selected_fitness;
		logic              uniform_fallback;
	} result_t;

	// Command codes carried in item_t.cmd.
	localparam logic CMD_LOAD = 1'b0;
	localparam logic CMD_DRAW = 1'b1;

endpackage

`default_nettype wire

### design/rws_ram.sv
`default_nettype none

module rws_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 64
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

### design/roulette_wheel_selector.sv
// Flow: a load passes through ST_LOAD and back to idle. A draw with a nonzero total walks the table
// in ST_WALK, reading one slot per cycle over the single table read port, then goes to ST_EMIT; a draw
// with a zero total goes through ST_MOD, ST_REM and ST_EMIT. A new transaction is taken only in idle,
// once the last one has left ST_EMIT; a result still waiting in the output register holds ST_EMIT.
// Reset: arst_n clears control state and the total, then a clearing pass in ST_CLEAR zeroes the table.
`default_nettype none

module roulette_wheel_selector
	import rws_pkg::*;
#(
	parameter int POP_SIZE = DEF_POP_SIZE
) (
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire logic    item_valid,
	output logic         item_ready,
	input  wire item_t   item,
	output logic         result_valid,
	input  wire logic    result_ready,
	output result_t      result
);

	// Table address width, running total width and product width all follow the population.
	localparam int AW     = (POP_SIZE > 1) ? $clog2(POP_SIZE) : 1;
	localparam int TOT_W  = FIT_W + AW;
	localparam int PROD_W = TOT_W + FRAC_W;

	// Reciprocal of the population, scaled so that the quotient of any 16-bit fraction is exact.
	localparam int RCP_SH  = FRAC_W + AW;
	localparam int RCP_W   = FRAC_W + 1;
	localparam int RPROD_W = FRAC_W + RCP_W;

	localparam logic [AW-1:0]     LAST_SLOT = AW'(POP_SIZE - 1);
	localparam logic [RCP_W-1:0]  RCP       = RCP_W'(((1 << RCP_SH) + POP_SIZE - 1) / POP_SIZE);
	localparam logic [FRAC_W-1:0] POP_F     = FRAC_W'(POP_SIZE);

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_LOAD,
		ST_WALK,
		ST_MOD,
		ST_REM,
		ST_EMIT
	} state_t;

	state_t state_q;

	// Running total of every table slot; it equals the exact sum once the clearing pass is done.
	logic [TOT_W-1:0]  total_q;

	// Clearing pass and load bookkeeping.
	logic [AW-1:0]     clr_q;
	logic [AW-1:0]     slot_q;
	logic [FIT_W-1:0]  fval_q;

	// Walk: target product, cumulative sum, read issue index and the index of the word in rdata.
	logic [PROD_W-1:0] target_q;
	logic [TOT_W-1:0]  cum_q;
	logic [AW-1:0]     rd_q;
	logic [AW-1:0]     pidx_q;
	logic              dv_q;

	// Uniform fallback: the quotient comes from a reciprocal multiply, then the remainder.
	logic [FRAC_W-1:0] rnd_q;
	logic [FRAC_W-1:0] quot_q;

	// Finished result waiting for the output register.
	result_t           hold_q;
	result_t           result_q;
	logic              result_valid_q;

	// Table port.
	logic              ram_we;
	logic [AW-1:0]     ram_waddr;
	logic [FIT_W-1:0]  ram_wdata;
	logic [AW-1:0]     ram_raddr;
	logic [FIT_W-1:0]  ram_rdata;

	logic [TOT_W-1:0]   cum_n;
	logic               hit;
	logic [RPROD_W-1:0] rcp_prod;
	logic [FRAC_W-1:0]  mod_full;
	logic               item_acc;
	logic               slot_ok;
	logic               emit_go;

	rws_ram #(
		.WIDTH(FIT_W),
		.DEPTH(POP_SIZE)
	) u_table (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	assign item_ready   = (state_q == ST_IDLE);
	assign item_acc     = item_valid && item_ready;
	assign result_valid = result_valid_q;
	assign result       = result_q;
	assign slot_ok      = (32'(item.slot_index) < POP_SIZE);

	// The output register takes a new result when it is empty or being drained this cycle.
	assign emit_go = (state_q == ST_EMIT) && (!result_valid_q || result_ready);

	// The accumulate-and-compare unit of the walk. A slot is chosen when its cumulative
	// sum, scaled by 65536, is strictly above total times the random fraction. The last slot
	// is the default choice, which the compare always reaches when the total is nonzero.
	assign cum_n = cum_q + TOT_W'(ram_rdata);
	assign hit   = ({cum_n, FRAC_W'(0)} > target_q) || (pidx_q == LAST_SLOT);

	// The reciprocal product gives the exact quotient of the fraction by the population; the
	// remainder is the fraction less quotient times population.
	assign rcp_prod = RPROD_W'(rnd_q) * RPROD_W'(RCP);
	assign mod_full = rnd_q - quot_q * POP_F;

	// The read address is the load slot while idle, so the old value is ready in ST_LOAD.
	always_comb begin
		ram_raddr = rd_q;
		ram_we    = 1'b0;
		ram_waddr = slot_q;
		ram_wdata = fval_q;
		case (state_q)
			ST_IDLE: begin
				ram_raddr = AW'(item.slot_index);
			end
			ST_CLEAR: begin
				ram_we    = 1'b1;
				ram_waddr = clr_q;
				ram_wdata = '0;
			end
			ST_LOAD: begin
				ram_we = 1'b1;
			end
			default: begin
				ram_raddr = rd_q;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_CLEAR;
			total_q        <= '0;
			clr_q          <= '0;
			slot_q         <= '0;
			fval_q         <= '0;
			target_q       <= '0;
			cum_q          <= '0;
			rd_q           <= '0;
			pidx_q         <= '0;
			dv_q           <= 1'b0;
			rnd_q          <= '0;
			quot_q         <= '0;
			hold_q         <= '0;
			result_q       <= '0;
			result_valid_q <= 1'b0;
		end else begin
			if (emit_go) begin
				result_q       <= hold_q;
				result_valid_q <= 1'b1;
			end else if (result_ready) begin
				result_valid_q <= 1'b0;
			end
			case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == LAST_SLOT) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (item_acc) begin
						if (item.cmd == CMD_LOAD) begin
							// A load beyond the population is dropped.
							if (slot_ok) begin
								slot_q  <= AW'(item.slot_index);
								fval_q  <= item.fitness_value;
								state_q <= ST_LOAD;
							end
						end else if (total_q == '0) begin
							rnd_q   <= item.random_fraction;
							state_q <= ST_MOD;
						end else begin
							target_q <= PROD_W'(total_q) * PROD_W'(item.random_fraction);
							cum_q    <= '0;
							rd_q     <= '0;
							dv_q     <= 1'b0;
							state_q  <= ST_WALK;
						end
					end
				end
				ST_LOAD: begin
					// The old slot value comes out of the table in this cycle.
					total_q <= total_q - TOT_W'(ram_rdata) + TOT_W'(fval_q);
					state_q <= ST_IDLE;
				end
				ST_WALK: begin
					if (dv_q && hit) begin
						hold_q.selected_slot    <= SLOT_W'(pidx_q);
						hold_q.selected_fitness <= ram_rdata;
						hold_q.uniform_fallback <= 1'b0;
						state_q                 <= ST_EMIT;
					end else begin
						if (dv_q) begin
							cum_q <= cum_n;
						end
						dv_q   <= 1'b1;
						pidx_q <= rd_q;
						rd_q   <= rd_q + 1'b1;
					end
				end
				ST_MOD: begin
					quot_q  <= FRAC_W'(rcp_prod >> RCP_SH);
					state_q <= ST_REM;
				end
				ST_REM: begin
					// A zero total means every slot holds zero.
					hold_q.selected_slot    <= SLOT_W'(mod_full);
					hold_q.selected_fitness <= '0;
					hold_q.uniform_fallback <= 1'b1;
					state_q                 <= ST_EMIT;
				end
				ST_EMIT: begin
					if (emit_go) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// While walking, the sum of the slots already passed stays below the total.
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_WALK) |-> (cum_q < total_q))
		else $error("walk cumulative sum reached the total");

	// The table is never written during a walk.
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_WALK) |-> !ram_we)
		else $error("table written during a walk");

	// The remainder always lands below the population size.
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_REM) |-> (mod_full < POP_F))
		else $error("remainder out of range");

	// A uniform choice is only delivered when the total is zero.
	assert property (@(posedge clk) disable iff (!arst_n)
		($rose(result_valid_q) && result_q.uniform_fallback) |-> (total_q == '0))
		else $error("uniform fallback with nonzero total");

endmodule

`default_nettype wire
